### hw/rtl/gbn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants
// Sizes of the point table, bucket grid and field widths for the
// grid bucket nearest-two search.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // Point table
    localparam int MAX_POINTS = 1024;
    localparam int ID_W       = 10;
    localparam int CNT_W      = 11;

    // Buckets
    localparam int BUCKET_CAP = 8;
    localparam int CAP_W      = 3;
    localparam int FILL_W     = 4;
    localparam int GRID_SIDE  = 16;
    localparam int NUM_BKT    = GRID_SIDE * GRID_SIDE;
    localparam int BKT_W      = 8;
    localparam int SIDE_W     = 4;

    // Fields
    localparam int POS_W  = 17;
    localparam int QUO_W  = 18;
    localparam int DIFF_W = 18;
    localparam int SQ_W   = 34;
    localparam int DIST_W = 35;
    localparam int BSZ_W  = 16;
    localparam int GDIM_W = 5;

    // Operation codes
    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_QUERY  = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_BUCKET_SIZE = 2'd0,
        CFG_GRID_WIDTH  = 2'd1,
        CFG_GRID_HEIGHT = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

endpackage

### hw/rtl/gbn_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface gbn_in_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         func;
    logic signed [gbn_pkg::POS_W-1:0]   pos_x;
    logic signed [gbn_pkg::POS_W-1:0]   pos_y;
    modport source (output valid, func, pos_x, pos_y, input ready);
    modport sink   (input valid, func, pos_x, pos_y, output ready);
endinterface

interface gbn_out_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [gbn_pkg::ID_W-1:0]      new_id;
    logic                          nearest_found;
    logic [gbn_pkg::ID_W-1:0]      nearest_id;
    logic [gbn_pkg::DIST_W-1:0]    nearest_dist_sq;
    logic                          second_found;
    logic [gbn_pkg::ID_W-1:0]      second_id;
    logic [gbn_pkg::DIST_W-1:0]    second_dist_sq;
    modport source (output valid, ok, new_id, nearest_found, nearest_id, nearest_dist_sq,
                    second_found, second_id, second_dist_sq, input ready);
    modport sink   (input valid, ok, new_id, nearest_found, nearest_id, nearest_dist_sq,
                    second_found, second_id, second_dist_sq, output ready);
endinterface

interface gbn_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    index;
    logic [gbn_pkg::BSZ_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/grid_bucket_nearest_two_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_bucket_nearest_two_search: uniform grid two-nearest search
// Point table with a bucket grid; insert, query nearest two, clear.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   carries one item (func, pos_x, pos_y); ready is high only while
//          the sequencer is idle, so one item is worked on at a time.
//   o_out  carries one result item per input item, held in an output
//          register until taken; a new item may be accepted meanwhile, but
//          its result waits until the register frees up.
//   i_cfg  writes bucket_size, grid_width, grid_height; always ready.
// Sequence:
//   clear and unused codes: straight to the output register.
//   insert: two divisions on the shared divider for the bucket
//          coordinates, then bucket fill lookup and store writes.
//   query: the same divisions, then per neighbor bucket a fill lookup,
//          and per scanned entry a member read, a point read, then the
//          squaring unit. Up to 72 entries are scanned (9 buckets of 8).
// Reset empties the point table and all buckets at once (per-bucket valid
// bits) and sets bucket_size 16, grid 16 x 16.
// ----------------------------------------------------------------------------
module grid_bucket_nearest_two_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gbn_in_if.sink      i_in,
    gbn_out_if.source   o_out,
    gbn_cfg_if.sink     i_cfg
);
    import gbn_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_DIVX = 12'b000000000010,
        S_DIVY = 12'b000000000100,
        S_CELL = 12'b000000001000,
        S_FILL = 12'b000000010000,
        S_CNT  = 12'b000000100000,
        S_MEM  = 12'b000001000000,
        S_PT   = 12'b000010000000,
        S_DIST = 12'b000100000000,
        S_WAIT = 12'b001000000000,
        S_NEXT = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } t_state;

    // Configuration
    logic [BSZ_W-1:0]   r_bsz;
    logic [GDIM_W-1:0]  r_gw;
    logic [GDIM_W-1:0]  r_gh;

    // Sequencer and item
    t_state             r_st;
    t_func              r_fn;
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;
    logic signed [QUO_W-1:0] r_bx;
    logic signed [QUO_W-1:0] r_by;
    logic [1:0]         r_ox;
    logic [1:0]         r_oy;
    logic [BKT_W-1:0]   r_b;
    logic               r_in;
    logic [FILL_W-1:0]  r_n;
    logic [FILL_W-1:0]  r_k;
    logic [CNT_W-1:0]   r_count;

    // Working result
    logic               r_ok;
    logic [ID_W-1:0]    r_nid;
    logic               r_f1;
    logic [ID_W-1:0]    r_id1;
    logic [DIST_W-1:0]  r_d1;
    logic               r_f2;
    logic [ID_W-1:0]    r_id2;
    logic [DIST_W-1:0]  r_d2;

    // Output register
    logic               r_ovld;
    logic               r_o_ok;
    logic [ID_W-1:0]    r_o_nid;
    logic               r_o_f1;
    logic [ID_W-1:0]    r_o_id1;
    logic [DIST_W-1:0]  r_o_d1;
    logic               r_o_f2;
    logic [ID_W-1:0]    r_o_id2;
    logic [DIST_W-1:0]  r_o_d2;

    // Memories
    logic [FILL_W-1:0]      fill_mem [NUM_BKT];
    logic [NUM_BKT-1:0]     r_fill_vld;
    logic [FILL_W-1:0]      r_fill_rd;
    logic                   r_fill_rd_vld;
    logic [ID_W-1:0]        mbr_mem [NUM_BKT * BUCKET_CAP];
    logic [ID_W-1:0]        r_mbr_rd;
    logic [2*POS_W-1:0]     pt_mem [MAX_POINTS];
    logic [2*POS_W-1:0]     r_pt_rd;

    // Combinational helpers
    logic                   in_acc;
    logic                   out_free;
    logic                   div_start;
    logic signed [POS_W-1:0] div_in;
    logic                   div_done;
    logic signed [QUO_W-1:0] div_q;
    logic                   sq_start;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                   sq_done;
    logic [DIST_W-1:0]      sq_dist;
    logic [GDIM_W-1:0]      cols;
    logic [GDIM_W-1:0]      rows;
    logic signed [QUO_W:0]  cx;
    logic signed [QUO_W:0]  cy;
    logic                   cell_in;
    logic [BKT_W:0]         cell_prod;
    logic [BKT_W-1:0]       cell_b;
    logic [FILL_W-1:0]      fill_cur;
    logic                   ins_ok;
    logic                   last_cell;
    logic                   fill_we;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ovld || o_out.ready;
    assign i_in.ready  = (r_st == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign cols = (r_gw > GDIM_W'(GRID_SIDE)) ? GDIM_W'(GRID_SIDE) : r_gw;
    assign rows = (r_gh > GDIM_W'(GRID_SIDE)) ? GDIM_W'(GRID_SIDE) : r_gh;

    // Neighbor cell coordinates and bucket number
    assign cx = $signed({r_bx[QUO_W-1], r_bx}) + $signed({17'd0, r_ox}) - 19'sd1;
    assign cy = $signed({r_by[QUO_W-1], r_by}) + $signed({17'd0, r_oy}) - 19'sd1;
    assign cell_in = !cx[QUO_W] && (cx[QUO_W-1:0] < QUO_W'(cols))
                  && !cy[QUO_W] && (cy[QUO_W-1:0] < QUO_W'(rows));
    assign cell_prod = (BKT_W+1)'(cy[SIDE_W-1:0]) * (BKT_W+1)'(cols)
                     + (BKT_W+1)'(cx[SIDE_W-1:0]);
    assign cell_b    = cell_prod[BKT_W-1:0];
    assign last_cell = (r_ox == 2'd2) && (r_oy == 2'd2);

    assign fill_cur = r_fill_rd_vld ? r_fill_rd : '0;
    assign ins_ok   = !r_count[CNT_W-1] && !(r_in && fill_cur >= FILL_W'(BUCKET_CAP));
    assign fill_we  = (r_st == S_CNT) && (r_fn == FN_INSERT) && ins_ok && r_in;

    // Shared divider: x on accept, y when x is done
    assign div_start = in_acc || ((r_st == S_DIVX) && div_done);
    assign div_in    = (r_st == S_IDLE) ? i_in.pos_x : r_py;

    gbn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_in),
        .i_divisor  (r_bsz),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // Squared distance to the stored point
    assign dx = $signed({r_px[POS_W-1], r_px})
              - $signed({r_pt_rd[2*POS_W-1], r_pt_rd[2*POS_W-1:POS_W]});
    assign dy = $signed({r_py[POS_W-1], r_py})
              - $signed({r_pt_rd[POS_W-1], r_pt_rd[POS_W-1:0]});
    assign sq_start = (r_st == S_DIST);

    gbn_sq u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_dx    (dx),
        .i_dy    (dy),
        .o_done  (sq_done),
        .o_dist  (sq_dist)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsz <= BSZ_W'(16);
            r_gw  <= GDIM_W'(GRID_SIDE);
            r_gh  <= GDIM_W'(GRID_SIDE);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_BUCKET_SIZE: r_bsz <= i_cfg.data;
                CFG_GRID_WIDTH:  r_gw  <= i_cfg.data[GDIM_W-1:0];
                CFG_GRID_HEIGHT: r_gh  <= i_cfg.data[GDIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Memories: registered reads, writes when an insert is given a new id
    always_ff @(posedge i_clk) begin
        r_fill_rd     <= fill_mem[r_b];
        r_fill_rd_vld <= r_fill_vld[r_b];
        r_mbr_rd      <= mbr_mem[{r_b, r_k[CAP_W-1:0]}];
        r_pt_rd       <= pt_mem[r_mbr_rd];
        if (fill_we) begin
            fill_mem[r_b] <= fill_cur + FILL_W'(1);
            mbr_mem[{r_b, fill_cur[CAP_W-1:0]}] <= r_count[ID_W-1:0];
        end
        if ((r_st == S_CNT) && (r_fn == FN_INSERT) && ins_ok) begin
            pt_mem[r_count[ID_W-1:0]] <= {r_px, r_py};
        end
    end

    // Bucket valid bits: cleared at reset and by a clear item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_vld <= '0;
        end else if (in_acc && t_func'(i_in.func) == FN_CLEAR) begin
            r_fill_vld <= '0;
        end else if (fill_we) begin
            r_fill_vld[r_b] <= 1'b1;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (t_func'(i_in.func))
                            FN_INSERT, FN_QUERY: r_st <= S_DIVX;
                            FN_CLEAR: begin
                                r_count <= '0;
                                r_st    <= S_OUT;
                            end
                            default: r_st <= S_OUT;
                        endcase
                    end
                end
                S_DIVX: if (div_done) r_st <= S_DIVY;
                S_DIVY: if (div_done) r_st <= S_CELL;
                S_CELL: begin
                    if (r_fn == FN_INSERT || cell_in) begin
                        r_st <= S_FILL;
                    end else begin
                        r_st <= S_NEXT;
                    end
                end
                S_FILL: r_st <= S_CNT;
                S_CNT: begin
                    if (r_fn == FN_INSERT) begin
                        if (ins_ok) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_st <= S_OUT;
                    end else if (fill_cur == '0) begin
                        r_st <= S_NEXT;
                    end else begin
                        r_st <= S_MEM;
                    end
                end
                S_MEM:  r_st <= S_PT;
                S_PT:   r_st <= S_DIST;
                S_DIST: r_st <= S_WAIT;
                S_WAIT: begin
                    if (sq_done) begin
                        if (r_k + FILL_W'(1) < r_n) begin
                            r_st <= S_MEM;
                        end else begin
                            r_st <= S_NEXT;
                        end
                    end
                end
                S_NEXT: r_st <= last_cell ? S_OUT : S_CELL;
                S_OUT: begin
                    if (out_free) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // Output valid: set on load, dropped when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if ((r_st == S_OUT) && out_free) begin
            r_ovld <= 1'b1;
        end else if (o_out.ready) begin
            r_ovld <= 1'b0;
        end
    end

    // Item datapath and working result
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                if (in_acc) begin
                    r_fn  <= t_func'(i_in.func);
                    r_px  <= i_in.pos_x;
                    r_py  <= i_in.pos_y;
                    r_ok  <= (t_func'(i_in.func) == FN_CLEAR);
                    r_nid <= '0;
                    r_f1  <= 1'b0;
                    r_id1 <= '0;
                    r_d1  <= '0;
                    r_f2  <= 1'b0;
                    r_id2 <= '0;
                    r_d2  <= '0;
                end
            end
            S_DIVX: if (div_done) r_bx <= div_q;
            S_DIVY: begin
                if (div_done) begin
                    r_by <= div_q;
                    // insert looks only at its own cell
                    r_ox <= (r_fn == FN_INSERT) ? 2'd1 : 2'd0;
                    r_oy <= (r_fn == FN_INSERT) ? 2'd1 : 2'd0;
                end
            end
            S_CELL: begin
                r_b  <= cell_in ? cell_b : '0;
                r_in <= cell_in;
            end
            S_CNT: begin
                r_n <= (fill_cur > FILL_W'(BUCKET_CAP)) ? FILL_W'(BUCKET_CAP) : fill_cur;
                r_k <= '0;
                if (r_fn == FN_INSERT && ins_ok) begin
                    r_ok  <= r_in;
                    r_nid <= r_count[ID_W-1:0];
                end
            end
            S_WAIT: begin
                if (sq_done) begin
                    r_k <= r_k + FILL_W'(1);
                    // strict compares keep the earlier point on ties
                    if (!r_f1 || sq_dist < r_d1) begin
                        r_f2  <= r_f1;
                        r_id2 <= r_id1;
                        r_d2  <= r_d1;
                        r_f1  <= 1'b1;
                        r_id1 <= r_mbr_rd;
                        r_d1  <= sq_dist;
                    end else if (!r_f2 || sq_dist < r_d2) begin
                        r_f2  <= 1'b1;
                        r_id2 <= r_mbr_rd;
                        r_d2  <= sq_dist;
                    end
                end
            end
            S_NEXT: begin
                // rows then columns
                if (r_ox == 2'd2) begin
                    r_ox <= 2'd0;
                    r_oy <= r_oy + 2'd1;
                end else begin
                    r_ox <= r_ox + 2'd1;
                end
            end
            default: ;
        endcase
    end

    // Output register load
    always_ff @(posedge i_clk) begin
        if ((r_st == S_OUT) && out_free) begin
            r_o_ok  <= r_ok;
            r_o_nid <= r_nid;
            r_o_f1  <= r_f1;
            r_o_id1 <= r_id1;
            r_o_d1  <= r_d1;
            r_o_f2  <= r_f2;
            r_o_id2 <= r_id2;
            r_o_d2  <= r_d2;
        end
    end

    assign o_out.valid           = r_ovld;
    assign o_out.ok              = r_o_ok;
    assign o_out.new_id          = r_o_nid;
    assign o_out.nearest_found   = r_o_f1;
    assign o_out.nearest_id      = r_o_id1;
    assign o_out.nearest_dist_sq = r_o_d1;
    assign o_out.second_found    = r_o_f2;
    assign o_out.second_id       = r_o_id2;
    assign o_out.second_dist_sq  = r_o_d2;

endmodule

### hw/rtl/gbn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_div: iterative bucket index divider
// Signed position divided by the bucket size, truncating toward zero.
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gbn_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [gbn_pkg::POS_W-1:0]   i_dividend,
    input  logic [gbn_pkg::BSZ_W-1:0]          i_divisor,
    output logic                               o_done,
    output logic signed [gbn_pkg::QUO_W-1:0]   o_quot
);
    import gbn_pkg::*;

    logic              r_busy;
    logic [4:0]        r_cnt;
    logic              r_neg;
    logic [POS_W-1:0]  r_q;
    logic [BSZ_W-1:0]  r_rem;
    logic [BSZ_W-1:0]  r_dvs;
    logic              r_done;

    logic [POS_W-1:0]  mag;
    logic [BSZ_W:0]    trial;
    logic              fits;
    logic [QUO_W-1:0]  q_ext;

    assign mag   = i_dividend[POS_W-1] ? POS_W'(-i_dividend) : POS_W'(i_dividend);
    assign trial = {r_rem, r_q[POS_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};
    assign q_ext = {1'b0, r_q};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(POS_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift one dividend bit into the remainder per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= mag;
            r_rem <= '0;
            r_neg <= i_dividend[POS_W-1];
            r_dvs <= (i_divisor == '0) ? BSZ_W'(1) : i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? BSZ_W'(trial - {1'b0, r_dvs}) : trial[BSZ_W-1:0];
            r_q   <= {r_q[POS_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? $signed(-q_ext) : $signed(q_ext);

endmodule

### hw/rtl/gbn_sq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_sq: squared distance unit
// One shared 17x17 multiplier squares dx, then dy, and the two are summed.
// The sum is registered in the last step, when o_done is raised.
// ----------------------------------------------------------------------------
module gbn_sq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [gbn_pkg::DIFF_W-1:0]  i_dx,
    input  logic signed [gbn_pkg::DIFF_W-1:0]  i_dy,
    output logic                               o_done,
    output logic [gbn_pkg::DIST_W-1:0]         o_dist
);
    import gbn_pkg::*;

    logic [1:0]        r_step;
    logic              r_done;
    logic [POS_W-1:0]  r_ax;
    logic [POS_W-1:0]  r_ay;
    logic [SQ_W-1:0]   r_p;
    logic [SQ_W-1:0]   r_acc;
    logic [DIST_W-1:0] r_sum;

    logic [POS_W-1:0]  mul_in;
    logic [SQ_W-1:0]   mul_out;

    // Shared multiplier: x on the first step, y on the second
    assign mul_in  = (r_step == 2'd1) ? r_ax : r_ay;
    assign mul_out = SQ_W'(mul_in) * SQ_W'(mul_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_step <= 2'd1;
            end else if (r_step == 2'd1) begin
                r_step <= 2'd2;
            end else if (r_step == 2'd2) begin
                r_step <= 2'd3;
            end else if (r_step == 2'd3) begin
                r_step <= 2'd0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ax <= i_dx[DIFF_W-1] ? POS_W'(-i_dx) : POS_W'(i_dx);
            r_ay <= i_dy[DIFF_W-1] ? POS_W'(-i_dy) : POS_W'(i_dy);
        end
        if (r_step == 2'd1 || r_step == 2'd2) begin
            r_p <= mul_out;
        end
        if (r_step == 2'd2) begin
            r_acc <= r_p;
        end
        if (r_step == 2'd3) begin
            r_sum <= DIST_W'(r_acc) + DIST_W'(r_p);
        end
    end

    assign o_done = r_done;
    assign o_dist = r_sum;

endmodule

### dv/grid_bucket_nearest_two_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_bucket_nearest_two_search_tb: self-checking bench for the grid search
// Drives insert, query and clear items with random gaps and output stalls,
// predicts every result with an in-bench model of the point table and
// buckets, and walks several grid and bucket size settings.
// ----------------------------------------------------------------------------
module grid_bucket_nearest_two_search_tb;
    import gbn_pkg::*;

    localparam int WDOG_LIMIT = 20000;

    // Expected result item
    typedef struct packed {
        logic                ok;
        logic [ID_W-1:0]     new_id;
        logic                nfound;
        logic [ID_W-1:0]     nid;
        logic [DIST_W-1:0]   ndist;
        logic                sfound;
        logic [ID_W-1:0]     sid;
        logic [DIST_W-1:0]   sdist;
    } t_result;

    // Directed stimulus row; chk says the typed-in result is compared too
    typedef struct {
        t_func       fn;
        int          px;
        int          py;
        bit          chk;
        t_result     res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    gbn_in_if  in_if ();
    gbn_out_if out_if ();
    gbn_cfg_if cfg_if ();

    grid_bucket_nearest_two_search u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // Shadow state of the block
    longint     pt_x [MAX_POINTS];
    longint     pt_y [MAX_POINTS];
    int         pt_count;
    int         bkt_fill [NUM_BKT];
    int         bkt_ids  [NUM_BKT][BUCKET_CAP];
    int         bsize_reg;
    int         gw_reg;
    int         gh_reg;

    t_result    expected_q [$];
    int         err_count;
    int         item_count;
    int         result_count;
    int         wdog;
    bit         stall_long;
    bit         timed_out;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch @%0t result %0d %s: got %0h want %0h",
                 $realtime, result_count, what, got, want);
        err_count++;
    endtask

    function automatic longint bucket_coord(input longint p);
        longint s;
        s = (bsize_reg == 0) ? 1 : bsize_reg;
        return p / s;
    endfunction

    // Apply one item to the shadow state and return its result
    function automatic t_result grid_predict(input t_func fn, input int px_i, input int py_i);
        t_result r;
        longint px, py, bx, by, cols, rows, dx, dy, d, d1, d2;
        bit on_grid, f1, f2;
        int b, id, id1, id2;
        r = '0;
        px = px_i; py = py_i;
        cols = (gw_reg > GRID_SIDE) ? GRID_SIDE : gw_reg;
        rows = (gh_reg > GRID_SIDE) ? GRID_SIDE : gh_reg;
        bx = bucket_coord(px);
        by = bucket_coord(py);
        f1 = 0; f2 = 0; id1 = 0; id2 = 0; d1 = 0; d2 = 0;
        case (fn)
            FN_INSERT: begin
                on_grid = bx >= 0 && bx < cols && by >= 0 && by < rows;
                b = on_grid ? int'(by * cols + bx) : 0;
                if (pt_count < MAX_POINTS && !(on_grid && bkt_fill[b] >= BUCKET_CAP)) begin
                    id = pt_count;
                    pt_x[id] = px;
                    pt_y[id] = py;
                    pt_count++;
                    r.new_id = id[ID_W-1:0];
                    if (on_grid) begin
                        bkt_ids[b][bkt_fill[b]] = id;
                        bkt_fill[b]++;
                        r.ok = 1'b1;
                    end
                end
            end
            FN_QUERY: begin
                for (longint y = by - 1; y <= by + 1; y++)
                    for (longint x = bx - 1; x <= bx + 1; x++) begin
                        if (x < 0 || x >= cols || y < 0 || y >= rows) continue;
                        b = int'(y * cols + x);
                        for (int k = 0; k < bkt_fill[b]; k++) begin
                            id = bkt_ids[b][k];
                            dx = px - pt_x[id];
                            dy = py - pt_y[id];
                            d = dx * dx + dy * dy;
                            if (!f1 || d < d1) begin
                                f2 = f1; id2 = id1; d2 = d1;
                                f1 = 1; id1 = id; d1 = d;
                            end else if (!f2 || d < d2) begin
                                f2 = 1; id2 = id; d2 = d;
                            end
                        end
                    end
                if (f1) begin
                    r.nfound = 1'b1; r.nid = id1[ID_W-1:0]; r.ndist = d1[DIST_W-1:0];
                end
                if (f2) begin
                    r.sfound = 1'b1; r.sid = id2[ID_W-1:0]; r.sdist = d2[DIST_W-1:0];
                end
            end
            FN_CLEAR: begin
                pt_count = 0;
                foreach (bkt_fill[i]) bkt_fill[i] = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Send one item after a random gap; the expectation is queued at acceptance.
    // Valid stays high when the next item follows with no gap.
    task automatic send_item(input t_func fn, input int px, input int py,
                             input bit chk, input t_result want);
        t_result r;
        int      gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.func  <= fn;
        in_if.pos_x <= px[POS_W-1:0];
        in_if.pos_y <= py[POS_W-1:0];
        do @(posedge i_clk); while (!in_if.ready);
        r = grid_predict(fn, px, py);
        if (chk && r != want) begin
            $display("directed row %0d: typed result disagrees with prediction", item_count);
            err_count++;
        end
        expected_q.insert(expected_q.size(), r);
        item_count++;
    endtask

    // Let the block drain, then let the tail of an idle clear settle
    task automatic wait_drained();
        while (expected_q.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val[BSZ_W-1:0];
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_BUCKET_SIZE: bsize_reg = val & 16'hFFFF;
            CFG_GRID_WIDTH:  gw_reg = val & 5'h1F;
            CFG_GRID_HEIGHT: gh_reg = val & 5'h1F;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic int rand_pos(input int span);
        int v;
        v = $urandom_range(0, span);
        return ($urandom_range(0, 7) == 0) ? -v : v;
    endfunction

    // One random phase of n items; mostly on-grid points and queries
    task automatic random_phase(input int n, input int span);
        t_func fn;
        int    sel;
        for (int i = 0; i < n && !timed_out; i++) begin
            sel = $urandom_range(0, 99);
            fn = sel < 45 ? FN_INSERT : sel < 93 ? FN_QUERY : sel < 96 ? FN_CLEAR : FN_NONE;
            if ($urandom_range(0, 19) == 0)
                send_item(fn, $urandom_range(0, 17'h1FFFF) - 65536,
                          $urandom_range(0, 17'h1FFFF) - 65536, 0, '0);
            else
                send_item(fn, rand_pos(span), rand_pos(span), 0, '0);
        end
        in_if.valid <= 1'b0;
    endtask

    // Result side: random stall per item, compare against oldest expectation
    initial begin
        t_result want;
        int      gap;
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (stall_long) begin
                out_if.ready <= 1'b0;
                @(posedge i_clk);
            end else begin
                gap = $urandom_range(0, 4);
                if (gap != 0) begin
                    out_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                out_if.ready <= 1'b1;
                do @(posedge i_clk); while (!out_if.valid && !stall_long);
                if (out_if.valid && out_if.ready) begin
                    if (expected_q.size() == 0) begin
                        $display("unexpected result item @%0t", $realtime);
                        err_count++;
                    end else begin
                        want = expected_q.pop_front();
                        if (out_if.ok !== want.ok) report("ok", out_if.ok, want.ok);
                        if (out_if.new_id !== want.new_id)
                            report("new_id", out_if.new_id, want.new_id);
                        if (out_if.nearest_found !== want.nfound)
                            report("nearest_found", out_if.nearest_found, want.nfound);
                        if (out_if.nearest_id !== want.nid)
                            report("nearest_id", out_if.nearest_id, want.nid);
                        if (out_if.nearest_dist_sq !== want.ndist)
                            report("nearest_dist_sq", out_if.nearest_dist_sq, want.ndist);
                        if (out_if.second_found !== want.sfound)
                            report("second_found", out_if.second_found, want.sfound);
                        if (out_if.second_id !== want.sid)
                            report("second_id", out_if.second_id, want.sid);
                        if (out_if.second_dist_sq !== want.sdist)
                            report("second_dist_sq", out_if.second_dist_sq, want.sdist);
                    end
                    result_count++;
                end
            end
        end
    end

    // Watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || stall_long)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired @%0t", $realtime);
            $display("== FAIL ==");
            $finish;
        end
    end

    t_row rows [$];

    // Append one directed row
    function automatic void add_row(input t_func fn, input int px, input int py,
                                    input bit chk, input t_result res);
        t_row row;
        row.fn  = fn;
        row.px  = px;
        row.py  = py;
        row.chk = chk;
        row.res = res;
        rows.insert(rows.size(), row);
    endfunction

    initial begin
        t_result r0;
        in_if.valid  = 1'b0;
        in_if.func   = FN_NONE;
        in_if.pos_x  = '0;
        in_if.pos_y  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_BUCKET_SIZE;
        cfg_if.data  = '0;
        err_count = 0; item_count = 0; result_count = 0; wdog = 0;
        stall_long = 0; timed_out = 0;
        pt_count = 0; bsize_reg = 16; gw_reg = 16; gh_reg = 16;
        foreach (bkt_fill[i]) bkt_fill[i] = 0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under reset registers (bucket size 16, 16x16 grid)
        r0 = '0;
        add_row(FN_QUERY, 0, 0, 1, r0);                    // empty table
        r0 = '0; r0.ok = 1;
        add_row(FN_INSERT, 0, 0, 1, r0);                   // id 0
        r0 = '0; r0.ok = 1; r0.new_id = 1;
        add_row(FN_INSERT, 16, 0, 1, r0);                  // id 1
        r0 = '0; r0.new_id = 2;
        add_row(FN_INSERT, -65536, 65535, 1, r0);          // off grid
        r0 = '0; r0.new_id = 3;
        add_row(FN_INSERT, 65535, -65536, 1, r0);
        r0 = '0; r0.nfound = 1; r0.ndist = 64; r0.sfound = 1; r0.sid = 1; r0.sdist = 64;
        add_row(FN_QUERY, 8, 0, 1, r0);                    // tie keeps earlier
        r0 = '0; r0.ok = 1; r0.new_id = 4;
        add_row(FN_INSERT, -15, 3, 1, r0);                 // truncates to 0
        add_row(FN_QUERY, -1, -1, 0, r0);
        add_row(FN_QUERY, 255, 255, 0, r0);
        for (int i = 0; i < 9; i++) add_row(FN_INSERT, 40 + i, 40, 0, r0);
        r0 = '0;
        add_row(FN_INSERT, 41, 41, 1, r0);                 // bucket full
        add_row(FN_QUERY, 44, 40, 0, r0);
        add_row(FN_NONE, 100, 100, 1, r0);                 // unused code
        r0 = '0; r0.ok = 1;
        add_row(FN_CLEAR, 0, 0, 1, r0);
        r0 = '0;
        add_row(FN_QUERY, 44, 40, 1, r0);
        foreach (rows[i]) send_item(rows[i].fn, rows[i].px, rows[i].py, rows[i].chk, rows[i].res);
        in_if.valid <= 1'b0;
        wait_drained();

        // Small cells, full grid
        write_reg(CFG_BUCKET_SIZE, 1);
        random_phase(90, 20);
        // Output held off while items keep coming
        stall_long = 1'b1;
        fork
            begin repeat (300) @(posedge i_clk); stall_long = 1'b0; end
            random_phase(6, 20);
        join
        wait_drained();

        // Zero size acts as one; oversized grid clamps
        write_reg(CFG_BUCKET_SIZE, 0);
        write_reg(CFG_GRID_WIDTH, 31);
        write_reg(CFG_GRID_HEIGHT, 17);
        random_phase(80, 20);
        wait_drained();

        // Narrow grid, odd size
        write_reg(CFG_BUCKET_SIZE, 37);
        write_reg(CFG_GRID_WIDTH, 1);
        write_reg(CFG_GRID_HEIGHT, 3);
        random_phase(80, 150);
        wait_drained();

        // Empty grid: everything is off grid
        write_reg(CFG_GRID_WIDTH, 0);
        random_phase(40, 200);
        wait_drained();

        // Largest buckets: whole plane in few cells
        write_reg(CFG_BUCKET_SIZE, 65535);
        write_reg(CFG_GRID_WIDTH, 2);
        write_reg(CFG_GRID_HEIGHT, 16);
        random_phase(80, 65535);
        wait_drained();

        // Mid grid to reach deep into the table
        write_reg(CFG_BUCKET_SIZE, 200);
        write_reg(CFG_GRID_WIDTH, 16);
        write_reg(CFG_GRID_HEIGHT, 16);
        send_item(FN_CLEAR, 0, 0, 0, '0);
        random_phase(250, 3200);
        wait_drained();

        $display("ran %0d items and %0d results over seven register settings,", item_count,
                 result_count);
        $display("covering off-grid, full-bucket, tie, clear and unused-code cases");
        if (err_count == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else begin
            $display("%0d errors, %0d results missing", err_count, expected_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
